// ===== rtl/css_pkg.sv =====
package css_pkg;

  localparam int CSS_SEG_BYTES = 1024;
  localparam int CSS_Q_DEPTH   = 4;
  localparam int CSS_CNT_W     = 11;
  localparam int CSS_IDX_W     = 1;
  localparam int CSS_CFG_W     = 16;

  localparam logic [CSS_CNT_W-1:0] CSS_HDR_LEN      = 11'd80;
  localparam logic [15:0]          CSS_DST_PORT_RST = 16'd5000;

  localparam logic [CSS_IDX_W-1:0] CSS_REG_SOURCE_PORT = 1'b0;
  localparam logic [CSS_IDX_W-1:0] CSS_REG_DEST_PORT   = 1'b1;

  localparam logic CSS_KIND_BYTE  = 1'b0;
  localparam logic CSS_KIND_REPLY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        last_of_file;
    logic        reply_is_ack;
    logic [15:0] reply_seq;
  } in_item_t;

  typedef struct packed {
    logic [15:0]          seq_number;
    logic [15:0]          src_port_out;
    logic [15:0]          dst_port_out;
    logic [CSS_CNT_W-1:0] length_field;
    logic [15:0]          checksum_out;
    logic [CSS_CNT_W-1:0] payload_count;
    logic                 is_retransmit;
  } out_item_t;

  // Work handed from the front part to the back part.
  typedef struct packed {
    logic                 retx;
    logic [15:0]          data_sum;
    logic [15:0]          seq;
    logic [15:0]          src;
    logic [15:0]          dst;
    logic [CSS_CNT_W-1:0] count;
  } cmd_t;

  // Ones' complement addition with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== rtl/css_chan_if.sv =====
interface css_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/css_front.sv =====
module css_front #(
  parameter int SEG_BYTES = css_pkg::CSS_SEG_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  css_chan_if.sink                      in_chan,
  input  logic                          cfg_we,
  input  logic [css_pkg::CSS_IDX_W-1:0] cfg_index,
  input  logic [css_pkg::CSS_CFG_W-1:0] cfg_wdata,
  input  logic                          q_full,
  output logic                          q_push,
  output css_pkg::cmd_t                 q_cmd
);

  logic [15:0]                   src_port_r, src_port_nxt;
  logic [15:0]                   dst_port_r, dst_port_nxt;
  logic [15:0]                   sum_r, sum_nxt;
  logic [7:0]                    held_r, held_nxt;
  logic                          pending_r, pending_nxt;
  logic [css_pkg::CSS_CNT_W-1:0] count_r, count_nxt;
  logic [15:0]                   seq_r, seq_nxt;
  logic                          awaiting_r, awaiting_nxt;
  logic                          sent_last_r, sent_last_nxt;

  css_pkg::in_item_t             item;
  logic                          accept;
  logic [15:0]                   word;
  logic [15:0]                   sum_add;
  logic [css_pkg::CSS_CNT_W-1:0] cnt_inc;
  logic                          seg_end;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign item          = in_chan.payload;

  // An odd byte that closes a segment is padded with a zero low byte.
  assign word    = pending_r ? {held_r, item.data_byte} : {item.data_byte, 8'h00};
  assign sum_add = css_pkg::oc_add(sum_r, word);
  assign cnt_inc = count_r + css_pkg::CSS_CNT_W'(1);
  assign seg_end = (cnt_inc >= css_pkg::CSS_CNT_W'(SEG_BYTES)) || item.last_of_file;

  always_comb begin
    src_port_nxt  = src_port_r;
    dst_port_nxt  = dst_port_r;
    sum_nxt       = sum_r;
    held_nxt      = held_r;
    pending_nxt   = pending_r;
    count_nxt     = count_r;
    seq_nxt       = seq_r;
    awaiting_nxt  = awaiting_r;
    sent_last_nxt = sent_last_r;
    q_push        = 1'b0;
    q_cmd.retx     = 1'b0;
    q_cmd.data_sum = sum_add;
    q_cmd.seq      = seq_r;
    q_cmd.src      = src_port_r;
    q_cmd.dst      = dst_port_r;
    q_cmd.count    = cnt_inc;

    if (cfg_we) begin
      unique case (cfg_index)
        css_pkg::CSS_REG_SOURCE_PORT: src_port_nxt = cfg_wdata;
        css_pkg::CSS_REG_DEST_PORT:   dst_port_nxt = cfg_wdata;
      endcase
    end

    if (accept) begin
      if (item.kind == css_pkg::CSS_KIND_BYTE) begin
        if (!awaiting_r) begin
          if (seg_end) begin
            q_push        = 1'b1;
            awaiting_nxt  = 1'b1;
            sent_last_nxt = item.last_of_file;
            sum_nxt       = 16'd0;
            held_nxt      = 8'd0;
            pending_nxt   = 1'b0;
            count_nxt     = '0;
          end else begin
            if (pending_r) begin
              sum_nxt = sum_add;
            end else begin
              held_nxt = item.data_byte;
            end
            pending_nxt = !pending_r;
            count_nxt   = cnt_inc;
          end
        end
      end else if (awaiting_r) begin
        if (item.reply_is_ack && (item.reply_seq == seq_r)) begin
          awaiting_nxt = 1'b0;
          seq_nxt      = sent_last_r ? 16'd0 : seq_r + 16'd1;
        end else begin
          q_push     = 1'b1;
          q_cmd.retx = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_port_r  <= 16'd0;
      dst_port_r  <= css_pkg::CSS_DST_PORT_RST;
      sum_r       <= 16'd0;
      held_r      <= 8'd0;
      pending_r   <= 1'b0;
      count_r     <= '0;
      seq_r       <= 16'd0;
      awaiting_r  <= 1'b0;
      sent_last_r <= 1'b0;
    end else begin
      src_port_r  <= src_port_nxt;
      dst_port_r  <= dst_port_nxt;
      sum_r       <= sum_nxt;
      held_r      <= held_nxt;
      pending_r   <= pending_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      awaiting_r  <= awaiting_nxt;
      sent_last_r <= sent_last_nxt;
    end
  end

endmodule

// ===== rtl/css_cmd_q.sv =====
module css_cmd_q (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  css_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output css_pkg::cmd_t head_cmd
);

  localparam int PTR_W = $clog2(css_pkg::CSS_Q_DEPTH);
  localparam int CNT_W = $clog2(css_pkg::CSS_Q_DEPTH + 1);

  css_pkg::cmd_t    mem_r [css_pkg::CSS_Q_DEPTH];
  css_pkg::cmd_t    head_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full       = (fill_r == CNT_W'(css_pkg::CSS_Q_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd   = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(css_pkg::CSS_Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(css_pkg::CSS_Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // The head register follows the entry at the next read pointer, taking the
  // incoming transaction directly when it becomes the head in this cycle.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= push_cmd;
    end else begin
      head_r <= mem_r[rd_ptr_nxt];
    end
  end

endmodule

// ===== rtl/css_back.sv =====
module css_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  css_pkg::cmd_t head_cmd,
  output logic          pop,
  css_chan_if.source    out_chan
);

  // Stage A holds partial checksums; the output register holds the descriptor.
  logic                          a_valid_r, a_valid_nxt;
  logic                          a_retx_r;
  logic [15:0]                   a_p_r;
  logic [15:0]                   a_q_r;
  logic [15:0]                   a_seq_r;
  logic [15:0]                   a_src_r;
  logic [15:0]                   a_dst_r;
  logic [css_pkg::CSS_CNT_W-1:0] a_count_r;
  logic                          o_valid_r, o_valid_nxt;
  css_pkg::out_item_t            o_item_r;

  logic                          adv_b;
  logic                          adv_a;
  logic [css_pkg::CSS_CNT_W-1:0] a_len;

  assign adv_b = !o_valid_r || out_chan.ready;
  assign adv_a = !a_valid_r || adv_b;
  assign pop   = head_valid && adv_a;
  assign a_len = css_pkg::CSS_HDR_LEN + a_count_r;

  assign out_chan.valid   = o_valid_r;
  assign out_chan.payload = o_item_r;

  always_comb begin
    a_valid_nxt = adv_a ? head_valid : a_valid_r;
    o_valid_nxt = adv_b ? a_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_retx_r  <= head_cmd.retx;
      a_p_r     <= css_pkg::oc_add(head_cmd.data_sum, head_cmd.seq);
      a_q_r     <= css_pkg::oc_add(head_cmd.src, head_cmd.dst);
      a_seq_r   <= head_cmd.seq;
      a_src_r   <= head_cmd.src;
      a_dst_r   <= head_cmd.dst;
      a_count_r <= head_cmd.count;
    end
  end

  // A retransmit always follows the descriptor it repeats, so the output
  // register already holds that descriptor and only the flag changes.
  always_ff @(posedge clk) begin
    if (adv_b && a_valid_r) begin
      if (a_retx_r) begin
        o_item_r.is_retransmit <= 1'b1;
      end else begin
        o_item_r.seq_number    <= a_seq_r;
        o_item_r.src_port_out  <= a_src_r;
        o_item_r.dst_port_out  <= a_dst_r;
        o_item_r.length_field  <= a_len;
        o_item_r.checksum_out  <=
          ~css_pkg::oc_add(css_pkg::oc_add(a_p_r, a_q_r), {5'd0, a_len});
        o_item_r.payload_count <= a_count_r;
        o_item_r.is_retransmit <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/checksummed_segment_sender.sv =====
// Stop-and-wait segment sender. Payload bytes (kind 0) are cut into segments
// of up to SEG_BYTES bytes and summed as big-endian words into a 16-bit ones'
// complement checksum that also covers the sequence number, both ports and the
// length field; at the end of a segment one header descriptor is produced and
// the block waits for a reply (kind 1). A matching ack advances the sequence
// number (back to 0 after the last segment of a file), any other reply resends
// the descriptor with is_retransmit set. Bytes taken while waiting and replies
// taken while not waiting are dropped. One transaction is taken every cycle;
// the input stalls only when the four-entry queue between the classifying
// front end and the checksum back end is full, which happens only while the
// result channel holds off. A descriptor passes the queue head, stage A and
// the output register in turn. Port registers are written through cfg_*.
module checksummed_segment_sender #(
  parameter int SEG_BYTES = css_pkg::CSS_SEG_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  css_chan_if.sink                      in_chan,
  css_chan_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [css_pkg::CSS_IDX_W-1:0] cfg_index,
  input  logic [css_pkg::CSS_CFG_W-1:0] cfg_wdata
);

  logic          q_full;
  logic          q_push;
  css_pkg::cmd_t q_cmd;
  logic          q_pop;
  logic          q_head_valid;
  css_pkg::cmd_t q_head_cmd;

  css_front #(
    .SEG_BYTES(SEG_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  css_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd)
  );

  css_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd),
    .pop       (q_pop),
    .out_chan  (out_chan)
  );

endmodule

// ===== sim/checksummed_segment_sender_tb.sv =====
module checksummed_segment_sender_tb;

  localparam int SEG_LEN      = css_pkg::CSS_SEG_BYTES;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE       = 16;
  localparam int CYCLE_LIMIT  = 600000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [css_pkg::CSS_IDX_W-1:0] cfg_index;
  logic [css_pkg::CSS_CFG_W-1:0] cfg_wdata;

  css_chan_if #(.payload_t(css_pkg::in_item_t)) in_if ();
  css_chan_if #(.payload_t(css_pkg::out_item_t)) out_if ();

  checksummed_segment_sender #(.SEG_BYTES(SEG_LEN)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sender state as the testbench sees it.
  logic [15:0]                   port_src;
  logic [15:0]                   port_dst;
  logic [15:0]                   sum_acc;
  logic [7:0]                    high_byte;
  logic                          have_high;
  logic [css_pkg::CSS_CNT_W-1:0] seg_fill;
  logic [15:0]                   seq_ctr;
  logic                          await_ack;
  css_pkg::out_item_t            last_desc;
  logic                          last_desc_eof;

  css_pkg::out_item_t pending_desc[$];
  css_pkg::out_item_t want_desc;
  int unsigned        payload_taken;
  int unsigned        mismatch_count;
  int unsigned        cycle_count = 0;
  logic               idle_on;

  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
    logic [16:0] total;
    total = {1'b0, acc} + {1'b0, word};
    if (total[16]) begin
      total = {1'b0, total[15:0]} + 17'd1;
    end
    return total[15:0];
  endfunction

  function automatic void predict_descriptor(input css_pkg::in_item_t it);
    css_pkg::out_item_t d;
    if (it.kind == css_pkg::CSS_KIND_BYTE) begin
      if (await_ack) begin
        return;
      end
      payload_taken++;
      if (have_high) begin
        sum_acc   = ones_add(sum_acc, {high_byte, it.data_byte});
        have_high = 1'b0;
      end else begin
        high_byte = it.data_byte;
        have_high = 1'b1;
      end
      seg_fill = seg_fill + 1'b1;
      if (seg_fill >= SEG_LEN || it.last_of_file) begin
        // An odd last byte is summed as the high half of a zero-padded word.
        if (have_high) begin
          sum_acc = ones_add(sum_acc, {high_byte, 8'h00});
        end
        d.length_field = css_pkg::CSS_HDR_LEN + seg_fill;
        sum_acc = ones_add(sum_acc, seq_ctr);
        sum_acc = ones_add(sum_acc, port_src);
        sum_acc = ones_add(sum_acc, port_dst);
        sum_acc = ones_add(sum_acc, {5'd0, d.length_field});
        d.seq_number    = seq_ctr;
        d.src_port_out  = port_src;
        d.dst_port_out  = port_dst;
        d.checksum_out  = ~sum_acc;
        d.payload_count = seg_fill;
        d.is_retransmit = 1'b0;
        last_desc     = d;
        last_desc_eof = it.last_of_file;
        await_ack     = 1'b1;
        sum_acc       = '0;
        high_byte     = '0;
        have_high     = 1'b0;
        seg_fill      = '0;
        pending_desc  = {pending_desc, d};
      end
    end else if (await_ack) begin
      payload_taken++;
      if (it.reply_is_ack && it.reply_seq == seq_ctr) begin
        await_ack = 1'b0;
        seq_ctr   = last_desc_eof ? 16'd0 : seq_ctr + 16'd1;
      end else begin
        d = last_desc;
        d.is_retransmit = 1'b1;
        pending_desc = {pending_desc, d};
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // The transaction is predicted at the edge where it is taken.
  task automatic send_item(input css_pkg::in_item_t item);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= item;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predict_descriptor(item);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    css_pkg::in_item_t it;
    it.kind         = css_pkg::CSS_KIND_BYTE;
    it.data_byte    = value;
    it.last_of_file = last;
    it.reply_is_ack = 1'($urandom_range(0, 1));
    it.reply_seq    = 16'($urandom());
    send_item(it);
  endtask

  task automatic send_reply(input logic is_ack, input logic [15:0] seq);
    css_pkg::in_item_t it;
    it.kind         = css_pkg::CSS_KIND_REPLY;
    it.data_byte    = 8'($urandom_range(0, 255));
    it.last_of_file = 1'($urandom_range(0, 1));
    it.reply_is_ack = is_ack;
    it.reply_seq    = seq;
    send_item(it);
  endtask

  // Sends a file of random bytes; each segment is answered after up to noise_max noise items.
  task automatic send_file(input int unsigned nbytes, input int unsigned noise_max);
    int unsigned noise;
    for (int unsigned i = 1; i <= nbytes; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == nbytes);
      if (await_ack) begin
        noise = $urandom_range(0, noise_max);
        repeat (noise) begin
          case ($urandom_range(0, 3))
            0: send_reply(1'b0, 16'($urandom()));
            1: send_reply(1'b1, seq_ctr ^ (16'd1 << $urandom_range(0, 15)));
            2: send_reply(1'b0, seq_ctr);
            default: send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          endcase
        end
        send_reply(1'b1, seq_ctr);
      end
    end
  endtask

  // Drops valid and lets every descriptor and queued transaction drain.
  task automatic wait_quiet();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_desc.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [css_pkg::CSS_IDX_W-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == css_pkg::CSS_REG_SOURCE_PORT) begin
      port_src = value;
    end else begin
      port_dst = value;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_ports();
    send_reply(1'b1, 16'd0);
    send_reply(1'b0, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_reply(1'b0, seq_ctr);
    send_reply(1'b1, 16'hFFFF);
    send_byte(8'h00, 1'b1);
    send_reply(1'b1, seq_ctr);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_reply(1'b1, seq_ctr);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_reply(1'b1, seq_ctr);
  endtask

  task automatic test_port_extremes();
    wait_quiet();
    write_reg(css_pkg::CSS_REG_SOURCE_PORT, 16'hFFFF);
    write_reg(css_pkg::CSS_REG_DEST_PORT, 16'hFFFF);
    repeat (3) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_reply(1'b1, seq_ctr);
    wait_quiet();
    write_reg(css_pkg::CSS_REG_SOURCE_PORT, 16'h0000);
    write_reg(css_pkg::CSS_REG_DEST_PORT, 16'h0000);
    send_byte(8'h00, 1'b1);
    // The resend must carry the ports of the first send, not the new ones.
    wait_quiet();
    write_reg(css_pkg::CSS_REG_SOURCE_PORT, 16'h1234);
    write_reg(css_pkg::CSS_REG_DEST_PORT, 16'hABCD);
    send_reply(1'b0, seq_ctr);
    send_reply(1'b1, seq_ctr);
    send_byte(8'h5A, 1'b1);
    send_reply(1'b1, seq_ctr);
  endtask

  // A full segment closes without the last byte, then a single odd byte ends the file.
  task automatic test_full_segments();
    wait_quiet();
    write_reg(css_pkg::CSS_REG_SOURCE_PORT, pick_port());
    write_reg(css_pkg::CSS_REG_DEST_PORT, pick_port());
    send_file(SEG_LEN + 1, 1);
  endtask

  task automatic test_random_traffic();
    int unsigned start_count;
    int unsigned files;
    int unsigned pick;
    int unsigned len;
    start_count = payload_taken;
    files = 0;
    while (payload_taken - start_count < RANDOM_ITEMS) begin
      if (files % 8 == 0) begin
        wait_quiet();
        write_reg(css_pkg::CSS_REG_SOURCE_PORT, pick_port());
        write_reg(css_pkg::CSS_REG_DEST_PORT, pick_port());
      end
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        send_reply(1'($urandom_range(0, 1)), 16'($urandom()));
      end
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        len = $urandom_range(1, 24);
      end else begin
        len = $urandom_range(25, 120);
      end
      send_file(len, 3);
      files++;
    end
    idle_on = 1'b1;
  endtask

  always begin : result_sink
    int unsigned stall;
    @(negedge clk);
    stall = idle_on ? $urandom_range(0, 6) : 0;
    if (stall != 0) begin
      out_if.ready <= 1'b0;
      repeat (stall) @(negedge clk);
    end
    out_if.ready <= 1'b1;
    do @(posedge clk); while (!(rst_n === 1'b1 && out_if.valid === 1'b1));
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_desc.size() == 0) begin
        $error("unexpected descriptor: seq_number %0d, payload_count %0d",
               out_if.payload.seq_number, out_if.payload.payload_count);
        mismatch_count++;
      end else begin
        want_desc = pending_desc.pop_front();
        check_field("seq_number", want_desc.seq_number, out_if.payload.seq_number);
        check_field("src_port_out", want_desc.src_port_out, out_if.payload.src_port_out);
        check_field("dst_port_out", want_desc.dst_port_out, out_if.payload.dst_port_out);
        check_field("length_field", 16'(want_desc.length_field),
                    16'(out_if.payload.length_field));
        check_field("checksum_out", want_desc.checksum_out, out_if.payload.checksum_out);
        check_field("payload_count", 16'(want_desc.payload_count),
                    16'(out_if.payload.payload_count));
        check_field("is_retransmit", 16'(want_desc.is_retransmit),
                    16'(out_if.payload.is_retransmit));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    idle_on        = 1'b1;
    mismatch_count = 0;
    payload_taken  = 0;
    port_src       = 16'd0;
    port_dst       = css_pkg::CSS_DST_PORT_RST;
    sum_acc        = '0;
    high_byte      = '0;
    have_high      = 1'b0;
    seg_fill       = '0;
    seq_ctr        = '0;
    await_ack      = 1'b0;
    last_desc      = '0;
    last_desc_eof  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_ports();
    test_port_extremes();
    test_full_segments();
    test_random_traffic();
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/css_pkg.sv
rtl/css_chan_if.sv
rtl/css_front.sv
rtl/css_cmd_q.sv
rtl/css_back.sv
rtl/checksummed_segment_sender.sv
sim/checksummed_segment_sender_tb.sv
